/* rtl/dpwm_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers for the dithered pwm generator
package dpwm_pkg;

   localparam int SETPOINT_W     = 21;
   localparam int FRAC_W         = 5;
   localparam int DUTY_W         = SETPOINT_W - FRAC_W;
   localparam int COMPARE_W      = 16;
   localparam int PERIOD_W       = 16;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 24;
   localparam int DEF_DITHER_LEN = 32;
   localparam int DEF_COUNT_BITS = 16;

   localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'hFFFF;
   localparam logic [COMPARE_W-1:0] COMPARE_MAX  = 16'hFFFF;

   // register index taken from paddr[2]
   localparam logic REG_PERIOD = 1'b0;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef struct packed {
      logic                  load;
      logic                  wrap;
      logic [SETPOINT_W-1:0] setpoint;
   } seq_cmd_type;

   function automatic logic [FRAC_W-1:0] rev5(input logic [FRAC_W-1:0] v);
      logic [FRAC_W-1:0] r;
      for (int b = 0; b < FRAC_W; b++) begin
         r[FRAC_W-1-b] = v[b];
      end
      return r;
   endfunction

endpackage

/* rtl/dithered_pwm_generator.sv */
`timescale 1ns / 1ps
// top level of the dithered pwm generator
//
//   group  dir  tdata / tuser / tlast
//   req    in   tdata: setpoint[20:0], zero pad   tuser: opcode
//   rsp    out  tdata: pwm_level, compare_value[16:1], zero pad   tlast: period_end
//   csr    in   period at byte address 0
//
// one request per cycle unless the result stalls; a request enters an input register
// and its result is formed by one pass of logic into the result register
// counter, sequence and compare state advance as a request moves to the result register
// reset is synchronous and clears all control and timer state, period returns to 65535
// a stalled result holds the result register; one more request waits in the input register
module dithered_pwm_generator #(
   parameter int DITHER_LEN = dpwm_pkg::DEF_DITHER_LEN,
   parameter int COUNT_BITS = dpwm_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dpwm_pkg::REQ_DATA_W-1:0]   req_tdata,  // setpoint, pad
   input  logic                              req_tuser,  // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dpwm_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // pwm_level, compare_value, pad
   output logic                              rsp_tlast,  // period_end
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dpwm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dpwm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dpwm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import dpwm_pkg::*;

   localparam int CMP_W = (COUNT_BITS > COMPARE_W) ? COUNT_BITS : COMPARE_W;

   logic [PERIOD_W-1:0]   period;
   logic [COMPARE_W-1:0]  entry_value;
   seq_cmd_type           seq_cmd;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_op_ff;
   logic [SETPOINT_W-1:0] in_sp_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_level_ff, out_level_in;
   logic [COMPARE_W-1:0]  out_compare_ff;
   logic                  out_end_ff;
   logic [COUNT_BITS-1:0] counter_ff, counter_in;
   logic [COMPARE_W-1:0]  active_ff, active_in;

   logic                  req_take;
   logic                  advance;
   logic                  is_load;
   logic                  wrap;

   dpwm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .period      (period)
   );

   dpwm_seq #(
      .DITHER_LEN (DITHER_LEN)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cmd         (seq_cmd),
      .entry_value (entry_value)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign is_load = in_op_ff == OP_LOAD;
   assign wrap    = !is_load && (CMP_W'(counter_ff) >= CMP_W'(period));

   assign seq_cmd.load     = advance && is_load;
   assign seq_cmd.wrap     = advance && wrap;
   assign seq_cmd.setpoint = in_sp_ff;

   always_comb begin
      counter_in = counter_ff;
      active_in  = active_ff;
      if (!is_load) begin
         if (wrap) begin
            counter_in = '0;
            active_in  = entry_value;
         end else begin
            counter_in = counter_ff + COUNT_BITS'(1);
         end
      end
   end

   assign out_level_in = CMP_W'(counter_in) < CMP_W'(active_in);
   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         counter_ff   <= '0;
         active_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            counter_ff <= counter_in;
            active_ff  <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff <= req_tuser;
         in_sp_ff <= req_tdata[SETPOINT_W-1:0];
      end
      if (advance) begin
         out_level_ff   <= out_level_in;
         out_compare_ff <= active_in;
         out_end_ff     <= wrap;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-COMPARE_W-1)'(0), out_compare_ff, out_level_ff};
   assign rsp_tlast  = out_end_ff;

`ifndef SYNTHESIS
   a_load_no_end: assert property (@(posedge clock) disable iff (reset)
      advance && is_load |=> !rsp_tlast)
      else $error("load request produced a period end");

   a_level_needs_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[COMPARE_W:1] != '0)
      else $error("pwm level high with zero compare");

   a_wrap_clears_counter: assert property (@(posedge clock) disable iff (reset)
      advance && wrap |=> counter_ff == '0)
      else $error("counter not cleared at period end");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request blocked without a full pipeline");

   a_end_reloads: assert property (@(posedge clock) disable iff (reset)
      advance && wrap |=> active_ff == $past(entry_value))
      else $error("compare not reloaded at period end");
`endif

endmodule

/* rtl/dpwm_csr.sv */
`timescale 1ns / 1ps
// configuration register file holding the period
module dpwm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dpwm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dpwm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dpwm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [dpwm_pkg::PERIOD_W-1:0]     period
);
   import dpwm_pkg::*;

   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] period_in;
   logic                wr_period;

   assign csr_pready = 1'b1;
   assign wr_period  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_PERIOD);
   assign period_in  = wr_period ? csr_pwdata[PERIOD_W-1:0] : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_PERIOD) begin
         csr_prdata = CSR_DATA_W'(period_ff);
      end
   end

   assign period = period_ff;

endmodule

/* rtl/dpwm_seq.sv */
`timescale 1ns / 1ps
// dither sequence: position, half setpoints, update flags and entry compare value
module dpwm_seq #(
   parameter int DITHER_LEN = dpwm_pkg::DEF_DITHER_LEN
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dpwm_pkg::seq_cmd_type            cmd,
   output logic [dpwm_pkg::COMPARE_W-1:0]   entry_value
);
   import dpwm_pkg::*;

   localparam int SEQ_LEN = 2 * DITHER_LEN;
   localparam int SEQ_W   = $clog2(SEQ_LEN);

   logic [SEQ_W-1:0]      pos_ff;
   logic [SEQ_W-1:0]      pos_in;
   logic [SETPOINT_W-1:0] pending_ff;
   logic [SETPOINT_W-1:0] pending_in;
   logic [SETPOINT_W-1:0] half_sp_ff [2];
   logic [SETPOINT_W-1:0] half_sp_in [2];
   logic [1:0]            half_upd_ff;
   logic [1:0]            half_upd_in;

   logic                  in_second;
   logic [SEQ_W-1:0]      local_idx;
   logic [FRAC_W-1:0]     frac_idx;
   logic [SETPOINT_W-1:0] cur_sp;
   logic [DUTY_W-1:0]     duty;
   logic                  dither_bit;
   logic [SEQ_W:0]        pos_inc;
   logic                  end_first;
   logic                  end_second;

   assign in_second  = pos_ff >= SEQ_W'(DITHER_LEN);
   assign local_idx  = in_second ? (pos_ff - SEQ_W'(DITHER_LEN)) : pos_ff;
   assign frac_idx   = FRAC_W'(local_idx);
   assign cur_sp     = half_sp_ff[in_second];
   assign duty       = cur_sp[SETPOINT_W-1:FRAC_W];
   assign dither_bit = rev5(~frac_idx) < cur_sp[FRAC_W-1:0];
   assign entry_value = (duty == COMPARE_MAX) ? COMPARE_MAX
                                              : (duty + DUTY_W'(dither_bit));

   assign pos_inc    = {1'b0, pos_ff} + (SEQ_W+1)'(1);
   assign end_first  = pos_inc == (SEQ_W+1)'(DITHER_LEN);
   assign end_second = pos_inc >= (SEQ_W+1)'(SEQ_LEN);

   always_comb begin
      pos_in      = pos_ff;
      pending_in  = pending_ff;
      half_sp_in  = half_sp_ff;
      half_upd_in = half_upd_ff;
      if (cmd.load) begin
         pending_in  = cmd.setpoint;
         half_upd_in = 2'b00;
      end else if (cmd.wrap) begin
         pos_in = end_second ? '0 : pos_inc[SEQ_W-1:0];
         if (end_first && !half_upd_ff[0]) begin
            half_sp_in[0]  = pending_ff;
            half_upd_in[0] = 1'b1;
         end
         if (end_second && !half_upd_ff[1]) begin
            half_sp_in[1]  = pending_ff;
            half_upd_in[1] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         pending_ff    <= '0;
         half_sp_ff[0] <= '0;
         half_sp_ff[1] <= '0;
         half_upd_ff   <= '0;
      end else begin
         pos_ff        <= pos_in;
         pending_ff    <= pending_in;
         half_sp_ff[0] <= half_sp_in[0];
         half_sp_ff[1] <= half_sp_in[1];
         half_upd_ff   <= half_upd_in;
      end
   end

endmodule

/* verif/dithered_pwm_generator_tb.sv */
`timescale 1ns / 1ps
// testbench for the dithered pwm generator: directed table, random phases, self-checking
module dithered_pwm_generator_tb;
   import dpwm_pkg::*;

   localparam int DITHER_LEN = DEF_DITHER_LEN;
   localparam int SEQ_LEN    = 2 * DITHER_LEN;
   localparam int COUNT_BITS = DEF_COUNT_BITS;

   typedef struct packed {
      logic                 level;
      logic [COMPARE_W-1:0] cmp;
      logic                 wrap;
   } pwm_result_type;

   typedef struct packed {
      logic                  is_csr;
      logic                  op;
      logic [SETPOINT_W-1:0] value;
      logic                  fixed;
      pwm_result_type        want;
   } stim_row_type;

   localparam pwm_result_type NO_CHECK = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dithered_pwm_generator dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // timer model state
   logic [PERIOD_W-1:0]   period_cfg = PERIOD_RESET;
   logic [COUNT_BITS-1:0] tmr_count = '0;
   logic [5:0]            seq_idx = '0;
   logic [COMPARE_W-1:0]  cur_compare = '0;
   logic [SETPOINT_W-1:0] pending_sp = '0;
   logic [SETPOINT_W-1:0] half_sp [2] = '{'0, '0};
   logic                  half_loaded [2] = '{1'b0, 1'b0};

   pwm_result_type exp_pwm_q [$];
   stim_row_type   stim_rows [$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int ticks_sent = 0;
   int loads_sent = 0;
   int wraps_seen = 0;
   int period_writes = 0;
   int max_compare = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results outstanding", exp_pwm_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [COMPARE_W-1:0] dither_compare(input logic [5:0] pos);
      logic [SETPOINT_W-1:0] sp;
      logic [FRAC_W-1:0]     idx;
      logic [FRAC_W-1:0]     flipped;
      logic [FRAC_W-1:0]     rev;
      logic [COMPARE_W:0]    sum;
      sp = half_sp[(pos / DITHER_LEN) % 2];
      idx = FRAC_W'((pos % DITHER_LEN) % 32);
      flipped = 5'd31 - idx;
      for (int b = 0; b < FRAC_W; b++) rev[FRAC_W-1-b] = flipped[b];
      sum = {1'b0, sp[SETPOINT_W-1:FRAC_W]} + ((rev < sp[FRAC_W-1:0]) ? 17'd1 : 17'd0);
      return (sum > {1'b0, COMPARE_MAX}) ? COMPARE_MAX : sum[COMPARE_W-1:0];
   endfunction

   function automatic void close_half(input int h);
      if (!half_loaded[h]) begin
         half_sp[h] = pending_sp;
         half_loaded[h] = 1'b1;
      end
   endfunction

   function automatic pwm_result_type next_pwm(input logic op,
                                               input logic [SETPOINT_W-1:0] sp);
      pwm_result_type r;
      int             pos;
      r.wrap = 1'b0;
      if (op == OP_LOAD) begin
         pending_sp = sp;
         half_loaded[0] = 1'b0;
         half_loaded[1] = 1'b0;
      end else if (tmr_count >= period_cfg) begin
         pos = seq_idx;
         tmr_count = '0;
         cur_compare = dither_compare(seq_idx);
         pos++;
         if (pos == DITHER_LEN) close_half(0);
         if (pos >= SEQ_LEN) begin
            close_half(1);
            pos = 0;
         end
         seq_idx = 6'(pos);
         r.wrap = 1'b1;
      end else begin
         tmr_count = tmr_count + 1'b1;
      end
      r.level = (tmr_count < cur_compare);
      r.cmp = cur_compare;
      return r;
   endfunction

   function automatic logic [SETPOINT_W-1:0] pick_setpoint();
      int sel;
      int duty;
      sel = $urandom_range(9);
      duty = $urandom_range(int'(period_cfg) + 2, 0);
      if (duty > 65535) duty = 65535;
      if (sel == 0) return {SETPOINT_W{1'b1}};
      else if (sel == 1) return {16'hFFFF, 5'($urandom_range(31))};
      else if (sel == 2) return {16'h0, 5'($urandom_range(31))};
      else if (sel < 6) return SETPOINT_W'($urandom);
      else return {16'(duty), 5'($urandom_range(31))};
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic send_req(input logic op, input logic [SETPOINT_W-1:0] sp,
                           input logic fixed, input pwm_result_type want);
      pwm_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b000, sp};
      do @(posedge clock); while (!req_tready);
      predicted = next_pwm(op, sp);
      exp_pwm_q.push_back(fixed ? want : predicted);
      if (op == OP_LOAD) loads_sent++;
      else ticks_sent++;
   endtask

   // stop offering, let every result come back, then give the pipeline time to empty
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (exp_pwm_q.size() == 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_PERIOD, 2'b00};
      csr_pwdata <= {16'h0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      period_cfg = value;
      period_writes++;
      @(negedge clock);
      if (csr_prdata !== CSR_DATA_W'(value))
         report_mismatch($sformatf("period readback %0d, expected %0d", csr_prdata, value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // receiver: random stalls plus an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      pwm_result_type got;
      pwm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.level = rsp_tdata[0];
         got.cmp = rsp_tdata[16:1];
         got.wrap = rsp_tlast;
         if (exp_pwm_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending (cmp %0d)", got.cmp));
         end else begin
            want = exp_pwm_q.pop_front();
            if (got.level !== want.level)
               report_mismatch($sformatf("pwm_level %b, expected %b", got.level, want.level));
            if (got.cmp !== want.cmp)
               report_mismatch($sformatf("compare_value %0d, expected %0d", got.cmp, want.cmp));
            if (got.wrap !== want.wrap)
               report_mismatch($sformatf("period_end %b, expected %b", got.wrap, want.wrap));
         end
         if (got.wrap === 1'b1) wraps_seen++;
         if (int'(got.cmp) > max_compare) max_compare = int'(got.cmp);
      end
   end

   initial begin
      stim_row_type        row;
      logic [PERIOD_W-1:0] phase_period;

      // directed table
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b1, '{1'b0, 16'd0, 1'b0}});
      stim_rows.push_back('{1'b0, OP_TICK, 21'h1FFFFF, 1'b1, '{1'b0, 16'd0, 1'b0}});
      stim_rows.push_back('{1'b0, OP_LOAD, 21'h1FFFFF, 1'b1, '{1'b0, 16'd0, 1'b0}});
      stim_rows.push_back('{1'b0, OP_LOAD, 21'd0, 1'b1, '{1'b0, 16'd0, 1'b0}});
      stim_rows.push_back('{1'b0, OP_LOAD, 21'h0AAAAA, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'h155555, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      // counter above the new period wraps at once
      stim_rows.push_back('{1'b1, OP_TICK, 21'd2, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b1, '{1'b0, 16'd0, 1'b1}});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      // period zero wraps on every tick
      stim_rows.push_back('{1'b1, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_LOAD, 21'h155555, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_LOAD, 21'h1FFFFF, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b1, OP_TICK, 21'h00FFFF, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b1, OP_TICK, 21'd1, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});
      stim_rows.push_back('{1'b0, OP_TICK, 21'd0, 1'b0, NO_CHECK});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.is_csr) begin
            drain();
            write_period(row.value[PERIOD_W-1:0]);
         end else begin
            send_req(row.op, row.value, row.fixed, row.want);
         end
      end

      // random phases: no idling, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin
               phase_period = 16'd1;
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               phase_period = 16'($urandom_range(6, 2));
               send_idle_pct = 49;
               recv_stall_pct = 0;
            end
            2: begin
               phase_period = 16'd3;
               send_idle_pct = 0;
               recv_stall_pct = 49;
            end
            default: begin
               phase_period = 16'($urandom_range(12, 1));
               send_idle_pct = 21;
               recv_stall_pct = 21;
            end
         endcase
         write_period(phase_period);
         // long back-pressure so the block fills and holds off requests
         if (phase == 2) hold_cycles = 80;
         for (int n = 0; n < 245; n++) begin
            if (phase == 1 && n == 120) drain();
            if ($urandom_range(99) < 7) send_req(OP_LOAD, pick_setpoint(), 1'b0, NO_CHECK);
            else send_req(OP_TICK, SETPOINT_W'($urandom), 1'b0, NO_CHECK);
         end
      end

      drain();
      repeat (10) @(posedge clock);

      $display("ran %0d ticks and %0d setpoint loads across %0d period writes",
               ticks_sent, loads_sent, period_writes);
      $display("saw %0d period ends, highest compare value %0d, %0d mismatches",
               wraps_seen, max_compare, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* dithered_pwm_generator.f */
rtl/dpwm_pkg.sv
rtl/dpwm_csr.sv
rtl/dpwm_seq.sv
rtl/dithered_pwm_generator.sv
verif/dithered_pwm_generator_tb.sv
